// ===== sv/cbe_pkg.sv =====
// Shared types and constants for the cubic Bezier point evaluator.
package cbe_pkg;

  // Curve parameter t: unsigned with 16 fraction bits, one integer bit for 1.0.
  localparam int T_FRAC = 16;
  localparam int T_W    = T_FRAC + 1;
  localparam logic [T_W-1:0] T_ONE = 17'h10000;

  // Squares of t and u, and the Bernstein weights with 48 fraction bits.
  localparam int SQ_W      = 2 * T_W;
  localparam int W_W       = 3 * T_FRAC + 1;
  localparam int W_LO_W    = 24;
  localparam int W_HI_W    = W_W - W_LO_W;
  localparam int ACC_SHIFT = 3 * T_FRAC;

  // Long division of the sample index: quotient bits per pipeline stage.
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS  = T_FRAC / DIV_STAGES;

  // Configuration port.
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = 16;
  localparam int NUM_CP    = 4;
  localparam int CP_SEL_W  = 2;
  localparam int NUM_AXES  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CP0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CP1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CP2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CP3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd4;

  localparam logic [CNT_W-1:0] COUNT_RESET = 16'd2;

  // How t is formed for one sample.
  typedef enum logic [1:0] {
    TMODE_ZERO,
    TMODE_ONE,
    TMODE_DIV
  } tmode_t;

  typedef logic [NUM_CP-1:0][CFG_W-1:0] cp_set_t;

  // Word leaving the parameter stages.
  typedef struct packed {
    logic           valid;
    logic [T_W-1:0] t;
    logic [T_W-1:0] u;
  } tparam_word_t;

  // Word leaving the weight stages.
  typedef struct packed {
    logic                       valid;
    logic [NUM_CP-1:0][W_W-1:0] w;
  } weights_word_t;

endpackage

// ===== sv/cbe_tparam.sv =====
// Parameter stages: maps a sample index to t and 1-t through a pipelined divider.
module cbe_tparam #(
  parameter int INDEX_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [INDEX_BITS-1:0]    in_index,
  input  logic [INDEX_BITS-1:0]    count_div,
  input  logic                     count_small,
  output cbe_pkg::tparam_word_t    out_word,
  input  logic                     out_stall
);

  localparam int NST = cbe_pkg::DIV_STAGES + 2;

  logic [NST-1:0] vld_r;
  logic [NST-1:0] en;

  logic [INDEX_BITS-1:0]        rem_r  [cbe_pkg::DIV_STAGES+1];
  logic [cbe_pkg::T_FRAC-1:0]   quo_r  [cbe_pkg::DIV_STAGES+1];
  cbe_pkg::tmode_t              mode_r [cbe_pkg::DIV_STAGES+1];
  cbe_pkg::tmode_t              mode_nxt;

  logic [cbe_pkg::T_W-1:0] t_r, u_r;
  logic [cbe_pkg::T_W-1:0] t_nxt, u_nxt;
  logic [INDEX_BITS:0]     round_sum;
  logic                    round_up;

  // A stage moves when it is empty or the stage after it moves.
  always_comb begin
    en[NST-1] = !vld_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Entry stage: sort out the degenerate counts and the saturated indexes.
  always_comb begin
    if (count_small) begin
      mode_nxt = cbe_pkg::TMODE_ZERO;
    end else if (in_index >= count_div) begin
      mode_nxt = cbe_pkg::TMODE_ONE;
    end else begin
      mode_nxt = cbe_pkg::TMODE_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0]  <= in_index;
      quo_r[0]  <= '0;
      mode_r[0] <= mode_nxt;
    end
  end

  // Restoring division of index * 2^16 by count-1, a few quotient bits per stage.
  for (genvar s = 0; s < cbe_pkg::DIV_STAGES; s++) begin : g_div
    logic [INDEX_BITS-1:0]      rem_nxt;
    logic [cbe_pkg::T_FRAC-1:0] quo_nxt;

    always_comb begin
      logic [INDEX_BITS:0] dbl;
      rem_nxt = rem_r[s];
      quo_nxt = quo_r[s];
      for (int b = 0; b < cbe_pkg::DIV_STEPS; b++) begin
        dbl = {rem_nxt, 1'b0};
        if (dbl >= {1'b0, count_div}) begin
          dbl     = dbl - {1'b0, count_div};
          quo_nxt = {quo_nxt[cbe_pkg::T_FRAC-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[cbe_pkg::T_FRAC-2:0], 1'b0};
        end
        rem_nxt = dbl[INDEX_BITS-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[s+1]) begin
        rem_r[s+1]  <= rem_nxt;
        quo_r[s+1]  <= quo_nxt;
        mode_r[s+1] <= mode_r[s];
      end
    end
  end

  // Round half up: the quotient grows by one when remainder plus half the
  // divisor reaches the divisor.
  assign round_sum = {1'b0, rem_r[cbe_pkg::DIV_STAGES]} + {2'b00, count_div[INDEX_BITS-1:1]};
  assign round_up  = round_sum >= {1'b0, count_div};

  always_comb begin
    case (mode_r[cbe_pkg::DIV_STAGES])
      cbe_pkg::TMODE_ZERO: t_nxt = '0;
      cbe_pkg::TMODE_ONE:  t_nxt = cbe_pkg::T_ONE;
      cbe_pkg::TMODE_DIV:  t_nxt = {1'b0, quo_r[cbe_pkg::DIV_STAGES]}
                                   + cbe_pkg::T_W'(round_up);
      default:             t_nxt = '0;
    endcase
    u_nxt = cbe_pkg::T_ONE - t_nxt;
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      t_r <= t_nxt;
      u_r <= u_nxt;
    end
  end

  assign out_word.valid = vld_r[NST-1];
  assign out_word.t     = t_r;
  assign out_word.u     = u_r;

endmodule

// ===== sv/cbe_weights.sv =====
// Weight stages: forms the four cubic Bernstein weights from t and 1-t.
module cbe_weights (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cbe_pkg::tparam_word_t  in_word,
  output logic                   in_stall,
  output cbe_pkg::weights_word_t out_word,
  input  logic                   out_stall
);

  localparam int NST    = 3;
  localparam int PROD_W = cbe_pkg::SQ_W + cbe_pkg::T_W;

  logic [NST-1:0] vld_r;
  logic [NST-1:0] en;

  logic [cbe_pkg::SQ_W-1:0] uu_r, tt_r, uu_nxt, tt_nxt;
  logic [cbe_pkg::T_W-1:0]  ua_r, ta_r;

  logic [PROD_W-1:0]                                 m_nxt [cbe_pkg::NUM_CP];
  logic [cbe_pkg::NUM_CP-1:0][cbe_pkg::W_W-1:0]      m_r;
  logic [cbe_pkg::NUM_CP-1:0][cbe_pkg::W_W-1:0]      w_r, w_nxt;

  always_comb begin
    en[NST-1] = !vld_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_word.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Squares.
  assign uu_nxt = cbe_pkg::SQ_W'(in_word.u) * cbe_pkg::SQ_W'(in_word.u);
  assign tt_nxt = cbe_pkg::SQ_W'(in_word.t) * cbe_pkg::SQ_W'(in_word.t);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      uu_r <= uu_nxt;
      tt_r <= tt_nxt;
      ua_r <= in_word.u;
      ta_r <= in_word.t;
    end
  end

  // Cubes and mixed terms; every one stays at or below 2^48.
  assign m_nxt[0] = PROD_W'(uu_r) * PROD_W'(ua_r);
  assign m_nxt[1] = PROD_W'(uu_r) * PROD_W'(ta_r);
  assign m_nxt[2] = PROD_W'(tt_r) * PROD_W'(ua_r);
  assign m_nxt[3] = PROD_W'(tt_r) * PROD_W'(ta_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < cbe_pkg::NUM_CP; k++) begin
        m_r[k] <= m_nxt[k][cbe_pkg::W_W-1:0];
      end
    end
  end

  // The two inner weights carry the binomial factor of three.
  always_comb begin
    w_nxt[0] = m_r[0];
    w_nxt[1] = m_r[1] + {m_r[1][cbe_pkg::W_W-2:0], 1'b0};
    w_nxt[2] = m_r[2] + {m_r[2][cbe_pkg::W_W-2:0], 1'b0};
    w_nxt[3] = m_r[3];
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      w_r <= w_nxt;
    end
  end

  assign out_word.valid = vld_r[NST-1];
  assign out_word.w     = w_r;

endmodule

// ===== sv/cbe_blend.sv =====
// Blend stages: weights the control points per axis, sums and rounds to Q8.8.
module cbe_blend #(
  parameter int COORD_BITS = 16
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  cbe_pkg::weights_word_t                             in_word,
  output logic                                               in_stall,
  input  cbe_pkg::cp_set_t                                   cp,
  output logic                                               out_valid,
  output logic [cbe_pkg::NUM_AXES-1:0][COORD_BITS-1:0]       out_point,
  input  logic                                               out_stall
);

  localparam int NST    = 3;
  localparam int PACK_W = (cbe_pkg::NUM_AXES * COORD_BITS > cbe_pkg::CFG_W)
                          ? cbe_pkg::NUM_AXES * COORD_BITS : cbe_pkg::CFG_W;
  localparam int HP_W   = COORD_BITS + cbe_pkg::W_HI_W + 1;
  localparam int LP_W   = COORD_BITS + cbe_pkg::W_LO_W + 1;
  localparam int SUM_W  = COORD_BITS + cbe_pkg::W_HI_W + 2;
  localparam int TOT_W  = SUM_W + cbe_pkg::W_LO_W + 1;
  localparam logic signed [TOT_W-1:0] ROUND_HALF =
    TOT_W'(1) << (cbe_pkg::ACC_SHIFT - 1);

  logic [NST-1:0] vld_r;
  logic [NST-1:0] en;

  logic signed [HP_W-1:0]  hp_r  [cbe_pkg::NUM_AXES][cbe_pkg::NUM_CP];
  logic signed [LP_W-1:0]  lp_r  [cbe_pkg::NUM_AXES][cbe_pkg::NUM_CP];
  logic signed [SUM_W-1:0] shi_r [cbe_pkg::NUM_AXES];
  logic signed [SUM_W-1:0] slo_r [cbe_pkg::NUM_AXES];
  logic [cbe_pkg::NUM_AXES-1:0][COORD_BITS-1:0] pt_r;

  always_comb begin
    en[NST-1] = !vld_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_word.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // One product lane per axis and control point; each weight is split in a
  // high and a low half so that every multiplier stays narrow.
  for (genvar a = 0; a < cbe_pkg::NUM_AXES; a++) begin : g_axis
    for (genvar k = 0; k < cbe_pkg::NUM_CP; k++) begin : g_cp
      logic [PACK_W-1:0]                   cp_ext;
      logic signed [COORD_BITS-1:0]        coord;
      logic signed [cbe_pkg::W_HI_W:0]     whi;
      logic signed [cbe_pkg::W_LO_W:0]     wlo;
      logic signed [HP_W-1:0]              hp_nxt;
      logic signed [LP_W-1:0]              lp_nxt;

      // Coordinates packed past the register width read as zero.
      assign cp_ext = PACK_W'(cp[k]);
      assign coord  = cp_ext[a*COORD_BITS +: COORD_BITS];
      assign whi    = {1'b0, in_word.w[k][cbe_pkg::W_W-1:cbe_pkg::W_LO_W]};
      assign wlo    = {1'b0, in_word.w[k][cbe_pkg::W_LO_W-1:0]};
      assign hp_nxt = coord * whi;
      assign lp_nxt = coord * wlo;

      always_ff @(posedge clk) begin
        if (en[0]) begin
          hp_r[a][k] <= hp_nxt;
          lp_r[a][k] <= lp_nxt;
        end
      end
    end

    logic signed [SUM_W-1:0] shi_nxt, slo_nxt;
    logic signed [TOT_W-1:0] tot;

    always_comb begin
      shi_nxt = '0;
      slo_nxt = '0;
      for (int k = 0; k < cbe_pkg::NUM_CP; k++) begin
        shi_nxt = shi_nxt + SUM_W'(hp_r[a][k]);
        slo_nxt = slo_nxt + SUM_W'(lp_r[a][k]);
      end
    end

    always_ff @(posedge clk) begin
      if (en[1]) begin
        shi_r[a] <= shi_nxt;
        slo_r[a] <= slo_nxt;
      end
    end

    // Adding one half and keeping the bits above the fraction is a floor, so
    // ties round toward plus infinity.
    assign tot = (TOT_W'(shi_r[a]) <<< cbe_pkg::W_LO_W) + TOT_W'(slo_r[a]) + ROUND_HALF;

    always_ff @(posedge clk) begin
      if (en[2]) begin
        pt_r[a] <= tot[cbe_pkg::ACC_SHIFT +: COORD_BITS];
      end
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_point = pt_r;

endmodule

// ===== sv/cubic_bezier_point_evaluator.sv =====
// Top level of the cubic Bezier point evaluator: configuration registers and pipeline.
//
// Usage: write the four control points (packed z:y:x, signed Q8.8 each) and the
// sample count through the cfg port while no word is in flight. Each input word
// carries a sample index i; the block evaluates the segment at t = i/(count-1),
// t = 0 for a count of one or zero and t = 1 for an index at or past count-1,
// and returns one output word with the rounded x, y and z coordinates.
// Pipeline: twelve register stages. A word passes six stages for t (entry, four
// divider stages of four quotient bits each, rounding), three for the weights
// (squares, cubes, factor of three) and three for blending (products, sums,
// rounding). Throughput: one word per cycle while the output is not stalled, set
// by the fully pipelined divider and multipliers.
// Reset: all valid bits clear, the control points go to zero and the sample
// count goes to two. A configuration write also reaches words in flight.
// Stall: a stage holds its word only when it is full and the stage after it
// holds too, so bubbles close up; in_stall rises once all twelve stages are
// full behind a stalled output word, which stays unchanged until taken.
module cubic_bezier_point_evaluator #(
  parameter int COORD_BITS = 16,
  parameter int INDEX_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [INDEX_BITS-1:0]             in_sample_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [COORD_BITS-1:0]      out_point_x,
  output logic signed [COORD_BITS-1:0]      out_point_y,
  output logic signed [COORD_BITS-1:0]      out_point_z,
  input  logic                              cfg_wr_en,
  input  logic [cbe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cbe_pkg::CFG_W-1:0]         cfg_data
);

  cbe_pkg::cp_set_t             cp_r;
  logic [cbe_pkg::CNT_W-1:0]    count_r;

  logic [INDEX_BITS+cbe_pkg::CNT_W-1:0] count_ext;
  logic [INDEX_BITS-1:0]                count_eff;
  logic [INDEX_BITS-1:0]                count_div;
  logic                                 count_small;

  cbe_pkg::tparam_word_t   tp_word;
  cbe_pkg::weights_word_t  wt_word;
  logic                    wt_in_stall;
  logic                    bl_in_stall;

  logic [cbe_pkg::NUM_AXES-1:0][COORD_BITS-1:0] point;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_r    <= '0;
      count_r <= cbe_pkg::COUNT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index) inside
        cbe_pkg::REG_CP0, cbe_pkg::REG_CP1, cbe_pkg::REG_CP2, cbe_pkg::REG_CP3: begin
          cp_r[cfg_index[cbe_pkg::CP_SEL_W-1:0]] <= cfg_data;
        end
        cbe_pkg::REG_COUNT: begin
          count_r <= cfg_data[cbe_pkg::CNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Only the low index-width bits of the sample count take part.
  assign count_ext   = {INDEX_BITS'(0), count_r};
  assign count_eff   = count_ext[INDEX_BITS-1:0];
  assign count_small = count_eff <= INDEX_BITS'(1);
  assign count_div   = count_eff - INDEX_BITS'(1);

  cbe_tparam #(
    .INDEX_BITS (INDEX_BITS)
  ) u_tparam (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_index    (in_sample_index),
    .count_div   (count_div),
    .count_small (count_small),
    .out_word    (tp_word),
    .out_stall   (wt_in_stall)
  );

  cbe_weights u_weights (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (tp_word),
    .in_stall  (wt_in_stall),
    .out_word  (wt_word),
    .out_stall (bl_in_stall)
  );

  cbe_blend #(
    .COORD_BITS (COORD_BITS)
  ) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (wt_word),
    .in_stall  (bl_in_stall),
    .cp        (cp_r),
    .out_valid (out_valid),
    .out_point (point),
    .out_stall (out_stall)
  );

  assign out_point_x = point[0];
  assign out_point_y = point[1];
  assign out_point_z = point[2];

  // Reset empties the whole pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

  // The input holds off only behind a valid output word that is stalled.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output is not stalled");

  // With a free output, no stage anywhere in the pipeline stalls.
  a_inner_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> (!in_stall && !wt_in_stall && !bl_in_stall))
    else $error("internal stall with a free output");

endmodule
